// ===== rtl/core/ipdb_pkg.sv =====
package ipdb_pkg;

    localparam int MAX_SECTORS_DEFAULT = 256;
    localparam int QUEUE_DEPTH = 2;

    localparam int BLOCK_W = 28;
    localparam int ADDR_W = 32;
    localparam int BYTES_W = 18;
    localparam int LEN_W = 16;

    localparam logic [7:0] DEVICE_BASE = 8'hE0;
    localparam logic [7:0] LBA_MODE_BIT = 8'h40;
    localparam logic [LEN_W:0] REGION_SPAN = 17'h10000;

    // One classified request waiting for the descriptor engine.
    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [ADDR_W-1:0] addr;
        logic [BYTES_W-1:0] bytes;
        logic [7:0] count_code;
    } ipdb_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ipdb_qstat_t;

endpackage

// ===== rtl/core/ipdb_front.sv =====
module ipdb_front #(
    parameter int MAX_SECTORS_PER_COMMAND = ipdb_pkg::MAX_SECTORS_DEFAULT
) (
    input  logic [27:0]              start_block,
    input  logic [31:0]              buffer_address,
    input  logic [17:0]              byte_count,
    output logic                     job_keep,
    output ipdb_pkg::ipdb_job_t      job
);
    import ipdb_pkg::*;

    localparam logic [9:0] MAX_SEC = 10'(MAX_SECTORS_PER_COMMAND);

    logic [9:0] sec_raw;
    logic [9:0] sectors;

    // Round up to whole sectors, then cap at the command limit.
    assign sec_raw = {1'b0, byte_count[17:9]} + {9'd0, |byte_count[8:0]};
    assign sectors = (sec_raw > MAX_SEC) ? MAX_SEC : sec_raw;

    // A request of zero bytes produces no descriptors and is dropped here.
    assign job_keep = (byte_count != '0);

    always_comb begin
        job.block = start_block;
        job.addr = buffer_address;
        job.bytes = BYTES_W'({sectors, 9'd0});
        // 256 sectors has zero low bits, which is the required encoding.
        job.count_code = sectors[7:0];
    end

endmodule

// ===== rtl/core/ipdb_queue.sv =====
module ipdb_queue #(
    parameter int DEPTH = ipdb_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ipdb_pkg::ipdb_job_t  push_data,
    input  logic                 pop,
    output ipdb_pkg::ipdb_job_t  head,
    output ipdb_pkg::ipdb_qstat_t stat
);
    import ipdb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ipdb_job_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = entries_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg == FULL_CNT);

endmodule

// ===== rtl/core/ipdb_back.sv =====
module ipdb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipdb_pkg::ipdb_job_t   head,
    input  ipdb_pkg::ipdb_qstat_t qstat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_device_byte,
    output logic [7:0]            m_sector_count_code,
    output logic [7:0]            m_block_low,
    output logic [7:0]            m_block_mid,
    output logic [7:0]            m_block_high,
    output logic [31:0]           m_region_base,
    output logic [15:0]           m_region_length,
    output logic                  m_end_of_table
);
    import ipdb_pkg::*;

    logic mid_reg, mid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTES_W-1:0] rem_reg, rem_next;
    logic valid_reg, valid_next;
    logic [7:0] device_reg, count_reg, low_reg, midb_reg, high_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0] len_reg;
    logic eot_reg;

    logic emit;
    logic [ADDR_W-1:0] cur_addr;
    logic [BYTES_W-1:0] cur_rem;
    logic [LEN_W:0] to_edge;
    logic [LEN_W:0] piece;
    logic last;

    // The first region of a job comes straight from the queue head; later
    // regions continue from the saved address and remaining byte count.
    assign cur_addr = mid_reg ? addr_reg : head.addr;
    assign cur_rem = mid_reg ? rem_reg : head.bytes;
    assign to_edge = REGION_SPAN - {1'b0, cur_addr[LEN_W-1:0]};
    assign last = (cur_rem <= BYTES_W'(to_edge));
    assign piece = last ? cur_rem[LEN_W:0] : to_edge;

    assign emit = !qstat.empty && (!valid_reg || m_ready);
    assign pop = emit && last;

    always_comb begin
        mid_next = mid_reg;
        addr_next = addr_reg;
        rem_next = rem_reg;
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            valid_next = 1'b1;
            mid_next = !last;
            addr_next = cur_addr + ADDR_W'(piece);
            rem_next = cur_rem - BYTES_W'(piece);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            mid_reg <= mid_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        rem_reg <= rem_next;
        if (emit) begin
            device_reg <= DEVICE_BASE | LBA_MODE_BIT | {4'd0, head.block[27:24]};
            count_reg <= head.count_code;
            low_reg <= head.block[7:0];
            midb_reg <= head.block[15:8];
            high_reg <= head.block[23:16];
            base_reg <= cur_addr;
            // A full 64 KiB region truncates to zero, its encoded form.
            len_reg <= piece[LEN_W-1:0];
            eot_reg <= last;
        end
    end

    assign m_valid = valid_reg;
    assign m_device_byte = device_reg;
    assign m_sector_count_code = count_reg;
    assign m_block_low = low_reg;
    assign m_block_mid = midb_reg;
    assign m_block_high = high_reg;
    assign m_region_base = base_reg;
    assign m_region_length = len_reg;
    assign m_end_of_table = eot_reg;

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("job popped from an empty queue");

    a_full_region_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region_length == '0) |-> (m_region_base[LEN_W-1:0] == '0))
        else $error("64 KiB region does not start on a 64 KiB boundary");

    a_no_boundary_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_region_length != '0) |->
        (({1'b0, m_region_base[LEN_W-1:0]} + {1'b0, m_region_length}) <= REGION_SPAN))
        else $error("region crosses a 64 KiB boundary");

    a_continue_after_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !last) |=> (mid_reg && !qstat.empty))
        else $error("job left before its last descriptor");
`endif

endmodule

// ===== rtl/core/ide_prd_descriptor_builder.sv =====
// READ DMA descriptor builder.
// Input channel (s_valid/s_ready): one request holding a 28-bit start block,
// a 32-bit buffer address and a byte count. The count is rounded up to
// 512-byte sectors and capped at MAX_SECTORS_PER_COMMAND sectors.
// Result channel (m_valid/m_ready): one item per physical region descriptor,
// at most three per request, each repeating the taskfile bytes. No region
// exceeds 64 KiB or crosses a 64 KiB boundary; the last one of a request
// has m_end_of_table set. A zero byte count gives no result.
// A request is classified as it is accepted and written into a two-entry
// job queue; the descriptor engine drains the queue head, one descriptor
// per cycle while the receiver takes them, into the output register. The
// first descriptor passes the job queue, then the output register. A
// request holds the engine through its descriptors (1 to 3), so the output
// register is the limit. When the receiver stalls, the output register
// holds, the engine waits, and s_ready falls once the queue is full.
// Reset (aresetn low at a clock edge) empties the queue and the output
// register; there is no clearing pass.
module ide_prd_descriptor_builder #(
    parameter int MAX_SECTORS_PER_COMMAND = ipdb_pkg::MAX_SECTORS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [27:0] s_start_block,
    input  logic [31:0] s_buffer_address,
    input  logic [17:0] s_byte_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_device_byte,
    output logic [7:0]  m_sector_count_code,
    output logic [7:0]  m_block_low,
    output logic [7:0]  m_block_mid,
    output logic [7:0]  m_block_high,
    output logic [31:0] m_region_base,
    output logic [15:0] m_region_length,
    output logic        m_end_of_table
);
    import ipdb_pkg::*;

    ipdb_job_t new_job;
    ipdb_job_t head;
    ipdb_qstat_t qstat;
    logic job_keep;
    logic push;
    logic pop;

    ipdb_front #(
        .MAX_SECTORS_PER_COMMAND(MAX_SECTORS_PER_COMMAND)
    ) u_front (
        .start_block(s_start_block),
        .buffer_address(s_buffer_address),
        .byte_count(s_byte_count),
        .job_keep(job_keep),
        .job(new_job)
    );

    assign s_ready = !qstat.full;
    assign push = s_valid && s_ready && job_keep;

    ipdb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_data(new_job),
        .pop(pop),
        .head(head),
        .stat(qstat)
    );

    ipdb_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .head(head),
        .qstat(qstat),
        .pop(pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_device_byte(m_device_byte),
        .m_sector_count_code(m_sector_count_code),
        .m_block_low(m_block_low),
        .m_block_mid(m_block_mid),
        .m_block_high(m_block_high),
        .m_region_base(m_region_base),
        .m_region_length(m_region_length),
        .m_end_of_table(m_end_of_table)
    );

endmodule

// ===== sim/ide_prd_descriptor_check.sv =====
`timescale 1ns / 100ps

module ide_prd_descriptor_check #(
    parameter int MAX_SECTORS = ipdb_pkg::MAX_SECTORS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [27:0] s_start_block,
    input  logic [31:0] s_buffer_address,
    input  logic [17:0] s_byte_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_device_byte,
    input  logic [7:0]  m_sector_count_code,
    input  logic [7:0]  m_block_low,
    input  logic [7:0]  m_block_mid,
    input  logic [7:0]  m_block_high,
    input  logic [31:0] m_region_base,
    input  logic [15:0] m_region_length,
    input  logic        m_end_of_table,
    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count
);
    import ipdb_pkg::*;

    localparam int SECTOR_BYTES = 512;
    localparam int MAX_REGIONS = 3;

    typedef struct {
        logic [7:0]        device_byte;
        logic [7:0]        sector_count_code;
        logic [7:0]        block_low;
        logic [7:0]        block_mid;
        logic [7:0]        block_high;
        logic [ADDR_W-1:0] region_base;
        logic [LEN_W-1:0]  region_length;
        logic              end_of_table;
    } prd_entry_t;

    prd_entry_t prd_expect_q[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, predicted %h", what, got, want));
    endtask

    // Cuts one READ DMA request into descriptors and queues them in order.
    task automatic predict_descriptors(input logic [BLOCK_W-1:0] blk,
                                       input logic [ADDR_W-1:0] base,
                                       input logic [BYTES_W-1:0] bytes);
        int sectors;
        int remaining;
        int to_edge;
        int piece;
        int n;
        logic [ADDR_W-1:0] addr;
        prd_entry_t entry;
        if (bytes != 0) begin
            sectors = (int'(bytes) + SECTOR_BYTES - 1) / SECTOR_BYTES;
            if (sectors > MAX_SECTORS)
                sectors = MAX_SECTORS;
            remaining = sectors * SECTOR_BYTES;
            addr = base;
            n = 0;
            entry.device_byte = DEVICE_BASE | LBA_MODE_BIT | {4'h0, blk[27:24]};
            entry.sector_count_code = (sectors == 256) ? 8'h00 : sectors[7:0];
            entry.block_low = blk[7:0];
            entry.block_mid = blk[15:8];
            entry.block_high = blk[23:16];
            while (remaining > 0 && n < MAX_REGIONS) begin
                to_edge = int'(REGION_SPAN) - int'(addr[15:0]);
                piece = remaining;
                if (piece > int'(REGION_SPAN))
                    piece = int'(REGION_SPAN);
                if (piece > to_edge)
                    piece = to_edge;
                remaining -= piece;
                n++;
                entry.region_base = addr;
                // A full 64 KiB region truncates to a length code of zero.
                entry.region_length = piece[15:0];
                entry.end_of_table = (remaining == 0 || n == MAX_REGIONS);
                prd_expect_q.push_back(entry);
                addr = addr + piece;
            end
        end
    endtask

    always @(posedge aclk) begin
        prd_entry_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (prd_expect_q.size() == 0) begin
                    report_mismatch("descriptor with no request behind it");
                end else begin
                    want = prd_expect_q.pop_front();
                    check_field("device_byte", m_device_byte, want.device_byte);
                    check_field("sector_count_code", m_sector_count_code,
                                want.sector_count_code);
                    check_field("block_low", m_block_low, want.block_low);
                    check_field("block_mid", m_block_mid, want.block_mid);
                    check_field("block_high", m_block_high, want.block_high);
                    check_field("region_base", m_region_base, want.region_base);
                    check_field("region_length", m_region_length, want.region_length);
                    check_field("end_of_table", m_end_of_table, want.end_of_table);
                    checked_count++;
                end
            end
            if (s_valid && s_ready)
                predict_descriptors(s_start_block, s_buffer_address, s_byte_count);
        end
        pending_count = prd_expect_q.size();
    end

endmodule

// ===== sim/ide_prd_descriptor_builder_test.sv =====
`timescale 1ns / 100ps

module ide_prd_descriptor_builder_test;
    import ipdb_pkg::*;

    localparam int MAX_SECTORS = MAX_SECTORS_DEFAULT;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 37;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [27:0] s_start_block;
    logic [31:0] s_buffer_address;
    logic [17:0] s_byte_count;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_device_byte;
    logic [7:0]  m_sector_count_code;
    logic [7:0]  m_block_low;
    logic [7:0]  m_block_mid;
    logic [7:0]  m_block_high;
    logic [31:0] m_region_base;
    logic [15:0] m_region_length;
    logic        m_end_of_table;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int quiet_cycles;

    ide_prd_descriptor_builder #(
        .MAX_SECTORS_PER_COMMAND(MAX_SECTORS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_start_block(s_start_block),
        .s_buffer_address(s_buffer_address),
        .s_byte_count(s_byte_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_device_byte(m_device_byte),
        .m_sector_count_code(m_sector_count_code),
        .m_block_low(m_block_low),
        .m_block_mid(m_block_mid),
        .m_block_high(m_block_high),
        .m_region_base(m_region_base),
        .m_region_length(m_region_length),
        .m_end_of_table(m_end_of_table)
    );

    ide_prd_descriptor_check #(
        .MAX_SECTORS(MAX_SECTORS)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_start_block(s_start_block),
        .s_buffer_address(s_buffer_address),
        .s_byte_count(s_byte_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_device_byte(m_device_byte),
        .m_sector_count_code(m_sector_count_code),
        .m_block_low(m_block_low),
        .m_block_mid(m_block_mid),
        .m_block_high(m_block_high),
        .m_region_base(m_region_base),
        .m_region_length(m_region_length),
        .m_end_of_table(m_end_of_table),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .checked_count(checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [27:0] blk, input logic [31:0] addr,
                                input logic [17:0] bytes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_start_block <= blk;
        s_buffer_address <= addr;
        s_byte_count <= bytes;
        do
            @(posedge aclk);
        while (!s_ready);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic [27:0] blk;
        logic [31:0] addr;
        logic [17:0] bytes;
        int pick;
        blk = 28'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
            addr = $urandom;
        else if (pick < 75)
            // Just below a 64 KiB boundary, so regions get split.
            addr = {16'($urandom), 7'h7F, 9'($urandom)};
        else
            addr = {16'($urandom), 16'h0000};
        pick = $urandom_range(99);
        if (pick < 8)
            bytes = 18'd0;
        else if (pick < 40)
            bytes = 18'($urandom_range(4096, 1));
        else if (pick < 75)
            bytes = 18'($urandom_range(131072, 1));
        else if (pick < 88)
            bytes = 18'($urandom_range(2, 1) * 65536 - 512 + $urandom_range(1024));
        else
            bytes = 18'($urandom);
        send_request(blk, addr, bytes);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    initial begin
        int phase;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_start_block = '0;
        s_buffer_address = '0;
        s_byte_count = '0;
        send_idle_pct = 33;
        recv_idle_pct = 72;
        requests_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: count extremes, boundary splits, saturation and wrap.
        send_request(28'h0000000, 32'h00000000, 18'd0);
        send_request(28'hFFFFFFF, 32'hFFFFFFFF, 18'h3FFFF);
        send_request(28'h0000000, 32'h00000000, 18'd1);
        send_request(28'h5A5A5A5, 32'h12340000, 18'd511);
        send_request(28'hA5A5A5A, 32'h00010200, 18'd512);
        send_request(28'h0123456, 32'h00020000, 18'd513);
        send_request(28'h1000000, 32'h00030000, 18'd65536);
        send_request(28'h2FFFFFF, 32'h00040000, 18'd131072);
        send_request(28'hFEDCBA9, 32'h0005FE00, 18'd131072);
        send_request(28'h7654321, 32'h00060000, 18'd131073);
        send_request(28'h0ABCDEF, 32'h00070010, 18'd130561);
        send_request(28'h0000001, 32'hFFFFFFFF, 18'd512);
        send_request(28'h0FFFFFF, 32'hFFFF0000, 18'd131072);
        send_request(28'hF000000, 32'hFFFFFE00, 18'd131072);
        send_request(28'h0000FF0, 32'h0000FFFF, 18'd65537);
        send_request(28'h00FF000, 32'h0008FFFE, 18'd2);
        send_request(28'h3333333, 32'h55555555, 18'd100000);
        send_request(28'hCCCCCCC, 32'hAAAAAAAA, 18'd1024);
        send_request(28'h0000000, 32'h00090000, 18'd0);
        send_request(28'h8000000, 32'h000A8000, 18'd65536);
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random();
            drain_results();
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d requests and %0d descriptors, directed cases first,",
                 requests_sent, checked_count);
        $display("then random requests under three sender and receiver idle mixes.");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
